// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: design/bha_pkg.sv
`default_nettype none

package bha_pkg;

  localparam int LED_COUNT = 16;

  localparam int FILL_W = $clog2(LED_COUNT + 1);
  localparam int IDX_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int FADE_MS  = 500;
  localparam int BASE_ADD = 100;

  // level = floor(51 * x / 100) with x = fade + 100, done as a multiply by
  // 51 * ceil(2^21 / 100) and a shift; exact for every x up to 600.
  localparam int X_W         = 10;
  localparam int RECIP_MUL   = 1069572;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 21;

  localparam int DEBOUNCE_RESET = 500;
  localparam int STEP_RESET     = 100;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_STEP     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MOOD_BLUE,
    MOOD_MAGENTA,
    MOOD_CYAN,
    MOOD_GREEN,
    MOOD_YELLOW,
    MOOD_RED
  } mood_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] step_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               heartbeat;
    logic               mic_level;
    logic signed [15:0] mood_value;
  } in_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_t;

  // One tick as handed from the front to the back.
  typedef struct packed {
    logic [X_W-1:0]    level_x;
    mood_e             mood;
    logic [FILL_W-1:0] fill;
    logic              inhale;
  } tick_t;

  // Clamping to 0..599 falls out of the open-ended first and last ranges.
  function automatic mood_e mood_class(input logic signed [15:0] m);
    mood_e c;
    if (m < 16'sd100)      c = MOOD_BLUE;
    else if (m < 16'sd200) c = MOOD_MAGENTA;
    else if (m < 16'sd300) c = MOOD_CYAN;
    else if (m < 16'sd400) c = MOOD_GREEN;
    else if (m < 16'sd500) c = MOOD_YELLOW;
    else                   c = MOOD_RED;
    return c;
  endfunction

  // Returns {red, green, blue} on/off.
  function automatic logic [2:0] mood_rgb(input mood_e c);
    logic [2:0] rgb;
    case (c)
      MOOD_BLUE:    rgb = 3'b001;
      MOOD_MAGENTA: rgb = 3'b101;
      MOOD_CYAN:    rgb = 3'b011;
      MOOD_GREEN:   rgb = 3'b010;
      MOOD_YELLOW:  rgb = 3'b110;
      MOOD_RED:     rgb = 3'b100;
      default:      rgb = 3'b000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// File: design/bha_front.sv
`default_nettype none

module bha_front import bha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  accept_i,
  input  wire in_t   item_i,
  output tick_t      tick_o
);

  localparam logic [X_W-1:0]    X_TOP  = X_W'(FADE_MS + BASE_ADD);
  localparam logic [X_W-1:0]    X_BASE = X_W'(BASE_ADD);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LED_COUNT);

  logic [31:0]       beat_time_q, beat_time_d;
  logic              prev_mic_q;
  logic [31:0]       last_edge_q, last_edge_d;
  logic [31:0]       last_step_q, last_step_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              rewinding_q, rewinding_d;
  logic              animating_q, animating_d;
  logic              inhale_q, inhale_d;
  logic              target_q, target_d;

  logic [31:0] elapsed;
  logic [31:0] since_edge;
  logic [31:0] since_step;
  logic        edge_ok;
  logic        step;

  always_comb begin
    beat_time_d = item_i.heartbeat ? item_i.now_ms : beat_time_q;
    elapsed     = item_i.now_ms - beat_time_d;
    since_edge  = item_i.now_ms - last_edge_q;
    since_step  = item_i.now_ms - last_step_q;

    edge_ok = !prev_mic_q && item_i.mic_level && (since_edge > {16'd0, cfg_i.debounce_ms});
    // An accepted edge restarts the step timer, so no step is taken on the same tick.
    step    = !edge_ok && (since_step > {16'd0, cfg_i.step_ms});

    last_edge_d = last_edge_q;
    last_step_d = last_step_q;
    rewinding_d = rewinding_q;
    animating_d = animating_q;
    target_d    = target_q;
    inhale_d    = inhale_q;
    fill_d      = fill_q;

    if (edge_ok) begin
      last_edge_d = item_i.now_ms;
      last_step_d = item_i.now_ms;
      if (!animating_q) begin
        target_d    = !inhale_q;
        rewinding_d = 1'b1;
        animating_d = 1'b1;
      end else begin
        rewinding_d = !rewinding_q;
        target_d    = !target_q;
      end
    end

    if (step) begin
      last_step_d = item_i.now_ms;
      if (rewinding_d) begin
        if (fill_q != '0) begin
          fill_d = fill_q - 1'b1;
        end else begin
          rewinding_d = 1'b0;
          inhale_d    = target_d;
        end
      end else begin
        if (fill_q < FILL_FULL) begin
          fill_d = fill_q + 1'b1;
        end else begin
          animating_d = 1'b0;
        end
      end
    end

    tick_o.level_x = (elapsed < 32'(FADE_MS)) ? (X_TOP - elapsed[X_W-1:0]) : X_BASE;
    tick_o.mood    = mood_class(item_i.mood_value);
    tick_o.fill    = fill_d;
    tick_o.inhale  = inhale_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_time_q <= '0;
      prev_mic_q  <= 1'b0;
      last_edge_q <= '0;
      last_step_q <= '0;
      fill_q      <= '0;
      rewinding_q <= 1'b0;
      animating_q <= 1'b0;
      inhale_q    <= 1'b1;
      target_q    <= 1'b1;
    end else if (accept_i) begin
      beat_time_q <= beat_time_d;
      prev_mic_q  <= item_i.mic_level;
      last_edge_q <= last_edge_d;
      last_step_q <= last_step_d;
      fill_q      <= fill_d;
      rewinding_q <= rewinding_d;
      animating_q <= animating_d;
      inhale_q    <= inhale_d;
      target_q    <= target_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bha_tickq.sv
`default_nettype none

module bha_tickq import bha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire tick_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output tick_t      data_o
);

  tick_t             mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/bha_back.sv
`default_nettype none

module bha_back import bha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  tick_valid_i,
  input  wire tick_t tick_i,
  output logic       tick_take_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output out_t       item_o
);

  localparam int PROD_W = X_W + RECIP_W;
  localparam int SUM_W  = FILL_W + 1;

  logic              desc_valid_q, desc_valid_d;
  logic [7:0]        level_q;
  logic [2:0]        rgb_q;
  logic [FILL_W-1:0] fill_q;
  logic              inhale_q;
  logic [IDX_W-1:0]  idx_q;

  logic              out_valid_q, out_valid_d;
  out_t              out_q;

  logic              out_free, emit, is_last, lit;
  logic [PROD_W-1:0] prod;
  logic [X_W-1:0]    quot;
  logic [7:0]        level;
  logic [SUM_W-1:0]  pos_sum;
  out_t              word;

  always_comb begin
    out_free    = !out_valid_q || pop_i;
    emit        = desc_valid_q && out_free;
    is_last     = (idx_q == IDX_W'(LED_COUNT - 1));
    tick_take_o = tick_valid_i && (!desc_valid_q || (emit && is_last));

    // Channel level for a lit component, saturated at full scale.
    prod  = PROD_W'(tick_i.level_x) * PROD_W'(RECIP_MUL);
    quot  = prod[PROD_W-1:RECIP_SHIFT];
    level = (quot > X_W'(255)) ? 8'hFF : quot[7:0];

    pos_sum = SUM_W'(idx_q) + SUM_W'(fill_q);
    if (inhale_q) begin
      lit = (pos_sum >= SUM_W'(LED_COUNT));
    end else begin
      lit = (SUM_W'(idx_q) >= SUM_W'(fill_q));
    end

    word.pixel_index = 6'(idx_q);
    word.red         = (lit && rgb_q[2]) ? level_q : 8'd0;
    word.green       = (lit && rgb_q[1]) ? level_q : 8'd0;
    word.blue        = (lit && rgb_q[0]) ? level_q : 8'd0;
    word.last_pixel  = is_last;

    desc_valid_d = desc_valid_q;
    if (tick_take_o) begin
      desc_valid_d = 1'b1;
    end else if (emit && is_last) begin
      desc_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      desc_valid_q <= desc_valid_d;
      out_valid_q  <= out_valid_d;
      if (tick_take_o) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take_o) begin
      level_q  <= level;
      rgb_q    <= mood_rgb(tick_i.mood);
      fill_q   <= tick_i.fill;
      inhale_q <= tick_i.inhale;
    end
    if (emit) begin
      out_q <= word;
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule

`default_nettype wire

// File: design/breath_heartbeat_led_animator.sv
// Channel   Direction  Handshake                     Payload
// input     in         push / full                   in_item_i   (in_t)
// result    out        pop / empty                   out_item_o  (out_t)
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each tick word gives LED_COUNT result words, one per cycle while the receiver keeps
// popping; the back end's pixel counter steps through them and sets the rate.
// The first result of a tick passes the tick queue, the back end's descriptor and its output register.
// A two-entry tick queue lets the front take ticks while the back is busy;
// full rises only when both entries wait, and a stalled result holds the back.
// Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none

module breath_heartbeat_led_animator import bha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_t         in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output out_t             out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     cfg_write;
  logic     accept;
  tick_t    front_tick, queue_tick;
  logic     queue_valid, queue_take;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= 16'(DEBOUNCE_RESET);
      cfg_q.step_ms     <= 16'(STEP_RESET);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_DEBOUNCE: cfg_q.debounce_ms <= pwdata[15:0];
        REG_STEP:     cfg_q.step_ms     <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
      REG_STEP:     prdata = {16'd0, cfg_q.step_ms};
      default:      prdata = '0;
    endcase
  end

  assign accept = push && !full;

  bha_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (in_item_i),
    .tick_o   (front_tick)
  );

  bha_tickq u_tickq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_tick),
    .full_o  (full),
    .pop_i   (queue_take),
    .valid_o (queue_valid),
    .data_o  (queue_tick)
  );

  bha_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (queue_valid),
    .tick_i       (queue_tick),
    .tick_take_o  (queue_take),
    .empty_o      (empty),
    .pop_i        (pop),
    .item_o       (out_item_o)
  );

endmodule

`default_nettype wire

// File: design/bha_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bha_checker import bha_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire in_t         in_item_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire out_t        out_item_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  logic unused_ok;
  assign unused_ok = ^{push, full, in_item_i, psel, penable, pwrite, paddr, pwdata, prdata};

  `ASSERT_IMPLIES(a_pready_high, clk_i, rst_ni, 1'b1, pready)

  `ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))

  // Within a tick the pixels come out in ascending order.
  `ASSERT_NEXT(a_pixel_advances, clk_i, rst_ni, pop && !empty && !out_item_o.last_pixel, empty || (out_item_o.pixel_index == $past(out_item_o.pixel_index) + 6'd1))

  // After the final pixel the next tick starts again at the first LED.
  `ASSERT_NEXT(a_tick_restarts, clk_i, rst_ni, pop && !empty && out_item_o.last_pixel, empty || (out_item_o.pixel_index == 6'd0))

  `ASSERT_IMPLIES(a_last_flag, clk_i, rst_ni, !empty, out_item_o.last_pixel == (out_item_o.pixel_index == 6'(LED_COUNT - 1)))

endmodule

bind breath_heartbeat_led_animator bha_checker u_bha_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  import bha_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int SETTLE      = 4;
  localparam int MAX_PRINTS  = 100;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        pop     = 1'b0;
  in_t         in_word = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        full;
  logic        empty;
  out_t        pixel_word;
  logic [31:0] prdata;
  logic        pready;

  breath_heartbeat_led_animator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (pixel_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Animator state as the block should hold it.
  logic [15:0] debounce_cfg = 16'(DEBOUNCE_RESET);
  logic [15:0] step_cfg     = 16'(STEP_RESET);
  logic [31:0] beat_time    = '0;
  logic [31:0] last_edge    = '0;
  logic [31:0] last_step    = '0;
  logic        mic_prev     = 1'b0;
  int unsigned fill_pos     = 0;
  bit          rewinding    = 1'b0;
  bit          animating    = 1'b0;
  bit          inhale       = 1'b1;
  bit          target_inhale = 1'b1;

  in_t  tick_q[$];
  out_t frame_pixels_q[$];

  int          errors        = 0;
  int          ticks_done    = 0;
  int          pixels_seen   = 0;
  int          reg_writes    = 0;
  int          stall_cycles  = 0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  int          rx_hold_left  = 0;
  bit          in_taken      = 1'b0;
  logic [31:0] clock_ms      = '0;
  logic        mic_now       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Advances the animator by one tick and queues the colour of every strip LED.
  task automatic compute_frame(input in_t t);
    int          mood;
    logic [31:0] elapsed;
    int unsigned fade;
    int unsigned level;
    logic [2:0]  rgb;
    bit          lit;
    out_t        px;
    mood = int'($signed(t.mood_value));
    if (mood < 0) mood = 0;
    if (mood > 599) mood = 599;
    case (mood_e'(mood / 100))
      MOOD_BLUE:    rgb = 3'b001;
      MOOD_MAGENTA: rgb = 3'b101;
      MOOD_CYAN:    rgb = 3'b011;
      MOOD_GREEN:   rgb = 3'b010;
      MOOD_YELLOW:  rgb = 3'b110;
      default:      rgb = 3'b100;
    endcase
    if (t.heartbeat) beat_time = t.now_ms;
    elapsed = t.now_ms - beat_time;
    fade = (elapsed < 32'(FADE_MS)) ? FADE_MS - elapsed : 0;
    level = (255 * (fade + BASE_ADD)) / FADE_MS;
    if (level > 255) level = 255;

    if (!mic_prev && t.mic_level && (t.now_ms - last_edge > 32'(debounce_cfg))) begin
      last_edge = t.now_ms;
      if (!animating) begin
        target_inhale = !inhale;
        rewinding = 1'b1;
        animating = 1'b1;
      end else begin
        rewinding = !rewinding;
        target_inhale = !target_inhale;
      end
      last_step = t.now_ms;
    end
    mic_prev = t.mic_level;

    if (t.now_ms - last_step > 32'(step_cfg)) begin
      last_step = t.now_ms;
      if (rewinding) begin
        if (fill_pos > 0) begin
          fill_pos--;
        end else begin
          rewinding = 1'b0;
          inhale = target_inhale;
        end
      end else if (fill_pos < LED_COUNT) begin
        fill_pos++;
      end else begin
        animating = 1'b0;
      end
    end

    for (int i = 0; i < LED_COUNT; i++) begin
      lit = inhale ? (i + fill_pos >= LED_COUNT) : (i >= fill_pos);
      px.pixel_index = 6'(i);
      px.red         = (lit && rgb[2]) ? 8'(level) : 8'd0;
      px.green       = (lit && rgb[1]) ? 8'(level) : 8'd0;
      px.blue        = (lit && rgb[0]) ? 8'(level) : 8'd0;
      px.last_pixel  = (i == LED_COUNT - 1);
      frame_pixels_q.push_back(px);
    end
    ticks_done++;
  endtask

  // Sender: a word is held until the block takes it.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_word <= tick_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off is counted down here, cycle by cycle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      pop <= 1'b0;
      rx_hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    in_taken = rst_ni && push && !full;
    if (in_taken) compute_frame(in_word);
    if (rst_ni && pop && !empty) begin
      pixels_seen++;
      if (frame_pixels_q.size() == 0) begin
        report_mismatch("pixel word with none expected, index", pixel_word.pixel_index, -1);
      end else begin
        want = frame_pixels_q.pop_front();
        if (pixel_word.pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", pixel_word.pixel_index, want.pixel_index);
        if (pixel_word.red !== want.red)
          report_mismatch("red", pixel_word.red, want.red);
        if (pixel_word.green !== want.green)
          report_mismatch("green", pixel_word.green, want.green);
        if (pixel_word.blue !== want.blue)
          report_mismatch("blue", pixel_word.blue, want.blue);
        if (pixel_word.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", pixel_word.last_pixel, want.last_pixel);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || psel) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no traffic for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Steps just past a rising edge so that every clocked process has settled.
  task automatic tick_wait();
    @(posedge clk_i);
    #1;
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || push || frame_pixels_q.size() != 0) tick_wait();
    repeat (SETTLE) tick_wait();
  endtask

  // Writes a register, with junk in the upper half, then reads it back.
  task automatic set_reg(input cfg_reg_e r, input logic [15:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'($urandom), v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DEBOUNCE: debounce_cfg = v;
      REG_STEP:     step_cfg = v;
    endcase
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== v) report_mismatch("register readback", prdata[15:0], v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  task automatic add_tick(input logic [31:0] now, input bit hb, input bit mic, input int mood);
    in_t t;
    t.now_ms     = now;
    t.heartbeat  = hb;
    t.mic_level  = mic;
    t.mood_value = 16'(mood);
    clock_ms = now;
    mic_now  = mic;
    tick_q.push_back(t);
  endtask

  // Mostly a steadily advancing clock with a chattering microphone, so that
  // chases start, reverse and run out; the rest is unrelated noise.
  task automatic add_random_tick();
    in_t         t;
    int unsigned span;
    if ($urandom_range(99) < 12) begin
      t.now_ms     = $urandom;
      t.heartbeat  = 1'($urandom_range(1));
      t.mic_level  = 1'($urandom_range(1));
      t.mood_value = 16'($urandom);
      clock_ms = t.now_ms;
      mic_now  = t.mic_level;
      tick_q.push_back(t);
    end else begin
      span = 32'(step_cfg) + 32'(step_cfg) / 2 + 60;
      if ($urandom_range(1)) mic_now = !mic_now;
      add_tick(clock_ms + $urandom_range(span), $urandom_range(99) < 20, mic_now,
               ($urandom_range(99) < 80) ? int'($urandom_range(700)) - 50
                                         : int'($signed(16'($urandom))));
    end
  endtask

  task automatic random_phase(input int n);
    repeat (n) add_random_tick();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    tick_wait();

    tx_idle_pct = 24;
    rx_idle_pct = 81;
    // Colour bands, fade right after reset and after a beat, debounced edges.
    add_tick(32'd0,    0, 0, -32768);
    add_tick(32'd250,  0, 0, 99);
    add_tick(32'd499,  0, 0, 100);
    add_tick(32'd500,  0, 0, 199);
    add_tick(32'd600,  1, 0, 200);
    add_tick(32'd700,  0, 0, 299);
    add_tick(32'd800,  0, 0, 300);
    add_tick(32'd900,  0, 0, 399);
    add_tick(32'd1000, 0, 0, 400);
    add_tick(32'd1100, 1, 0, 499);
    add_tick(32'd1200, 0, 0, 500);
    add_tick(32'd1300, 0, 0, 599);
    add_tick(32'd1400, 0, 0, 600);
    add_tick(32'd1500, 0, 0, 32767);
    add_tick(32'd1600, 0, 1, 250);
    add_tick(32'd1700, 0, 0, 150);
    add_tick(32'd1800, 0, 1, 350);
    add_tick(32'd1900, 0, 0, 450);
    add_tick(32'd2200, 1, 1, 50);
    add_tick(32'd2400, 0, 0, 550);
    add_tick(32'hFFFF_FF00, 1, 0, -1);
    add_tick(32'hFFFF_FFFF, 0, 1, 32767);
    add_tick(32'h0000_0064, 0, 0, -32768);
    drain();

    set_reg(REG_DEBOUNCE, 16'h0000);
    set_reg(REG_STEP, 16'h0000);
    random_phase(50);

    tx_idle_pct = 81;
    rx_idle_pct = 24;
    set_reg(REG_DEBOUNCE, 16'hFFFF);
    set_reg(REG_STEP, 16'hFFFF);
    random_phase(50);

    // The receiver stalls long enough for the block to back up to its input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_reg(REG_DEBOUNCE, 16'($urandom_range(600, 100)));
    set_reg(REG_STEP, 16'($urandom_range(120, 10)));
    rx_hold_left = 150;
    random_phase(60);

    set_reg(REG_DEBOUNCE, 16'(DEBOUNCE_RESET));
    set_reg(REG_STEP, 16'(STEP_RESET));
    random_phase(40);

    repeat (TAIL_CYCLES) tick_wait();
    $display("Checked %0d ticks as %0d pixel words across %0d register writes,",
             ticks_done, pixels_seen, reg_writes);
    $display("with fades, all six colours, debounced chases and a backed-up input.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/bha_pkg.sv
design/bha_front.sv
design/bha_tickq.sv
design/bha_back.sv
design/breath_heartbeat_led_animator.sv
design/bha_checker.sv
tb/sv/tb_top.sv
